[src/wva_pkg.sv]
// ----------------------------------------------------------------------------
// wva_pkg
// Shared types and constants of the wavetable voice with ADSR envelope.
// ----------------------------------------------------------------------------
package wva_pkg;

  localparam int TableDepthDef   = 64;
  localparam int LfoRomDepthDef  = 256;
  localparam int MaxSubstepsDef  = 5;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 27;

  // Command opcodes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_NOTE_ON  = 3'd1;
  localparam logic [2:0] OP_NOTE_OFF = 3'd2;
  localparam logic [2:0] OP_BEND     = 3'd3;
  localparam logic [2:0] OP_WHEEL    = 3'd4;
  localparam logic [2:0] OP_TABLE    = 3'd5;

  // Envelope phases
  localparam logic [2:0] ENV_IDLE    = 3'd0;
  localparam logic [2:0] ENV_ATTACK  = 3'd1;
  localparam logic [2:0] ENV_DECAY   = 3'd2;
  localparam logic [2:0] ENV_SUSTAIN = 3'd3;
  localparam logic [2:0] ENV_RELEASE = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_ATTACK   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_DECAY    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_RELEASE  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_SUSTAIN  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_OUT_LVL  = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_RATE     = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_MOD      = 3'd6;
  localparam logic [CfgIndexW-1:0] CFG_MODE     = 3'd7;

  localparam logic [23:0] ENV_FULL = 24'd8388608;
  localparam logic [26:0] ACC_ONE  = 27'd16777216;
  localparam logic [26:0] ACC_MAX  = 27'h7FFFFFF;
  localparam logic [15:0] BEND_ONE = 16'd16384;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [23:0]        phase_step;
    logic [23:0]        lfo_step;
    logic [15:0]        bend_ratio;
    logic [6:0]         wheel_value;
    logic [5:0]         table_index;
    logic signed [15:0] table_value;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               playing;
  } smp_t;

endpackage

[src/wavetable_voice_adsr.sv]
// ----------------------------------------------------------------------------
// wavetable_voice_adsr
// One synthesizer voice: wave table oscillator, sine LFO and linear ADSR.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on cmd (cmd_valid / cmd_stall). A tick produces one sample
// transaction on smp (smp_valid / smp_stall); note on, note off, bend, wheel
// and table write produce none and are handled in the idle state. The block
// works on one command at a time; a tick runs a sequencer over the multiplier
// datapath for up to MAX_SUBSTEPS sub-steps, as many as the rate accumulator
// releases, each via the LFO states when modulation is on, then the table
// read and quantize states; an idle-voice tick goes straight to output.
// The sine LFO chain takes 8 dependent registered steps per sub-step.
// The wave table RAM has one write port and a registered read port; entries
// hold garbage until written. Configuration writes are taken every cycle
// (cfg_ready is tied high) and are expected only while the voice is idle.
// Reset (rst, synchronous) restores register defaults and clears the voice.
// A finished sample waits in the output register while smp_stall is high;
// the next command is accepted meanwhile, and a following tick holds in its
// last step until that register is free.
// ----------------------------------------------------------------------------
module wavetable_voice_adsr #(
  parameter int TABLE_DEPTH   = wva_pkg::TableDepthDef,
  parameter int LFO_ROM_DEPTH = wva_pkg::LfoRomDepthDef,
  parameter int MAX_SUBSTEPS  = wva_pkg::MaxSubstepsDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  wva_pkg::cmd_t                  cmd,
  output logic                           smp_valid,
  input  logic                           smp_stall,
  output wva_pkg::smp_t                  smp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wva_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [wva_pkg::CfgDataW-1:0]   cfg_data
);

  localparam int TW  = $clog2(TABLE_DEPTH);
  localparam int IW  = $clog2(LFO_ROM_DEPTH);
  localparam int PW  = 24 + IW;
  localparam int PPW = IW + 41;
  localparam int NW  = $clog2(MAX_SUBSTEPS + 1);

  localparam logic [IW:0]   LfoDepthC = (IW + 1)'(LFO_ROM_DEPTH);
  localparam logic [40:0]   PRecip    =
    41'(((64'd1 << 40) + 64'(LFO_ROM_DEPTH) - 64'd1) / 64'(LFO_ROM_DEPTH));
  localparam logic [20:0]   WRecip    = 21'd1056833;
  localparam logic [8:0]    TdC       = 9'(TABLE_DEPTH);
  localparam logic [NW-1:0] MaxSubC   = NW'(MAX_SUBSTEPS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENV  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_L0   = 4'd3;
  localparam logic [3:0] S_L1   = 4'd4;
  localparam logic [3:0] S_L2   = 4'd5;
  localparam logic [3:0] S_L3   = 4'd6;
  localparam logic [3:0] S_L4   = 4'd7;
  localparam logic [3:0] S_L5   = 4'd8;
  localparam logic [3:0] S_L6   = 4'd9;
  localparam logic [3:0] S_L7   = 4'd10;
  localparam logic [3:0] S_RD   = 4'd11;
  localparam logic [3:0] S_Q    = 4'd12;
  localparam logic [3:0] S_O1   = 4'd13;
  localparam logic [3:0] S_O2   = 4'd14;
  localparam logic [3:0] S_O3   = 4'd15;

  // Configuration registers
  logic [23:0] attack_step, decay_step, release_step, sustain_level;
  logic [15:0] output_level, mod_depth;
  logic [26:0] rate_step;
  logic [6:0]  mode;

  // Voice state
  logic [3:0]         state;
  logic [2:0]         env_phase;
  logic [23:0]        env_level, osc_phase, lfo_phase;
  logic [26:0]        rate_accum;
  logic signed [15:0] held_sample;
  logic [23:0]        note_phase_step, note_lfo_step;
  logic [15:0]        bend_held;
  logic [6:0]         wheel_held;
  logic [NW-1:0]      nsub;

  // Datapath registers
  logic [IW-1:0]       lfo_idx;
  logic [19:0]         wm;
  logic [15:0]         p16;
  logic [12:0]         wdep;
  logic [1:0]          quad;
  logic [14:0]         xr;
  logic [15:0]         x2;
  logic [13:0]         inner;
  logic [14:0]         mid;
  logic [16:0]         depth;
  logic [14:0]         sval;
  logic [23:0]         offset;
  logic [23:0]         adv;
  logic signed [40:0]  prod1;
  logic signed [57:0]  prod2;

  // Wave table
  logic [15:0]   wave_mem [TABLE_DEPTH];
  logic [15:0]   rd_data;
  logic [TW-1:0] rd_idx, wr_idx;
  logic          wr_en;

  // Combinational
  logic               cmd_acc;
  logic               mod_en;
  logic signed [25:0] lvl, lvl_next, sus26;
  logic [2:0]         phase_next;
  logic [27:0]        acc_sum;
  logic [PW-1:0]      lprod;
  logic [PPW-1:0]     pprod;
  logic [40:0]        wprod;
  logic [29:0]        xsq;
  logic [26:0]        x2k;
  logic [29:0]        x2i;
  logic [29:0]        vprod;
  logic [16:0]        vraw;
  logic [31:0]        mag;
  logic [32:0]        mag_up;
  logic [23:0]        eff;
  logic [8:0]         ridx_w, widx_w;
  logic [5:0]         ridx6;
  logic [39:0]        aprod;
  logic [4:0]         qbits;
  logic [15:0]        qu;
  logic signed [18:0] res;
  logic signed [15:0] res_sat;
  logic               out_free;

  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mod_en    = mode[0] || (wheel_held != 7'd0);
  assign out_free  = !smp_valid || !smp_stall;

  // Envelope update
  always_comb begin
    lvl        = signed'({2'b00, env_level});
    sus26      = (sustain_level > wva_pkg::ENV_FULL) ? signed'({2'b00, wva_pkg::ENV_FULL})
                                                   : signed'({2'b00, sustain_level});
    lvl_next   = lvl;
    phase_next = env_phase;
    case (env_phase)
      wva_pkg::ENV_ATTACK: begin
        lvl_next = lvl + signed'({2'b00, attack_step});
        if (lvl_next >= signed'({2'b00, wva_pkg::ENV_FULL})) begin
          lvl_next   = signed'({2'b00, wva_pkg::ENV_FULL});
          phase_next = wva_pkg::ENV_DECAY;
        end
      end
      wva_pkg::ENV_DECAY: begin
        if (lvl > sus26) begin
          lvl_next = lvl - signed'({2'b00, decay_step});
          if (lvl_next <= sus26) begin
            lvl_next   = sus26;
            phase_next = wva_pkg::ENV_SUSTAIN;
          end
        end else begin
          lvl_next   = sus26;
          phase_next = wva_pkg::ENV_SUSTAIN;
        end
      end
      wva_pkg::ENV_RELEASE: begin
        lvl_next = lvl - signed'({2'b00, release_step});
        if (lvl_next <= 26'sd0) begin
          lvl_next   = 26'sd0;
          phase_next = wva_pkg::ENV_IDLE;
        end
      end
      default: lvl_next = lvl;
    endcase
  end

  // Datapath combinational terms, each multiply with its own product
  always_comb begin
    acc_sum = {1'b0, rate_accum} + {1'b0, rate_step};
    lprod   = PW'(lfo_phase) * PW'(LfoDepthC);
    pprod   = PPW'(lfo_idx) * PPW'(PRecip);
    wprod   = 41'(wm) * 41'(WRecip);
    xsq     = 30'(xr) * 30'(xr);
    x2k     = 27'(x2) * 27'd1306;
    x2i     = 30'(x2) * 30'(inner);
    vprod   = 30'(xr) * 30'(mid);
    vraw    = {vprod[29:14], 1'b0};
    mag     = 32'(sval) * 32'(depth);
    mag_up  = 33'(mag) + 33'd127;
    eff     = osc_phase + offset;
    ridx6   = mode[1] ? eff[23:18] : {eff[23:19], 1'b0};
    ridx_w  = (9'(ridx6) >= TdC) ? (TdC - 9'd1) : 9'(ridx6);
    rd_idx  = ridx_w[TW-1:0];
    widx_w  = (9'(cmd.table_index) >= TdC) ? (9'(cmd.table_index) - TdC)
                                           : 9'(cmd.table_index);
    wr_idx  = widx_w[TW-1:0];
    wr_en   = cmd_acc && (cmd.opcode == wva_pkg::OP_TABLE);
    aprod   = 40'(note_phase_step) * 40'(bend_held);
    qbits   = mode[6:2];
    qu      = rd_data ^ 16'h8000;
    if ((qbits != 5'd0) && (qbits < 5'd16)) begin
      qu = qu & (16'hFFFF << (5'd16 - qbits));
    end
    qu      = qu ^ 16'h8000;
    res     = prod2[57:39];
    if (res > 19'sd32767) begin
      res_sat = 16'sh7FFF;
    end else if (res < -19'sd32768) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res[15:0];
    end
  end

  // Wave table RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wave_mem[wr_idx] <= cmd.table_value;
    end
    rd_data <= wave_mem[rd_idx];
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= wva_pkg::ENV_FULL;
      decay_step    <= wva_pkg::ENV_FULL;
      release_step  <= wva_pkg::ENV_FULL;
      sustain_level <= wva_pkg::ENV_FULL;
      output_level  <= 16'd32768;
      rate_step     <= wva_pkg::ACC_ONE;
      mod_depth     <= 16'd0;
      mode          <= 7'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wva_pkg::CFG_ATTACK:  attack_step   <= cfg_data[23:0];
        wva_pkg::CFG_DECAY:   decay_step    <= cfg_data[23:0];
        wva_pkg::CFG_RELEASE: release_step  <= cfg_data[23:0];
        wva_pkg::CFG_SUSTAIN: sustain_level <= cfg_data[23:0];
        wva_pkg::CFG_OUT_LVL: output_level  <= cfg_data[15:0];
        wva_pkg::CFG_RATE:    rate_step     <= cfg_data[26:0];
        wva_pkg::CFG_MOD:     mod_depth     <= cfg_data[15:0];
        wva_pkg::CFG_MODE:    mode          <= cfg_data[6:0];
        default:              mode          <= mode;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    lfo_idx <= lprod[PW-1:24];
    wm      <= 20'(wheel_held) * 20'd6554;
    p16     <= pprod[39:24];
    wdep    <= wprod[39:27];
    quad    <= p16[15:14];
    xr      <= p16[14] ? (15'd16384 - {1'b0, p16[13:0]}) : {1'b0, p16[13:0]};
    x2      <= xsq[29:14];
    inner   <= 14'd10583 - x2k[26:14];
    mid     <= 15'd25736 - x2i[28:14];
    depth   <= 17'(mod_depth) + 17'(wdep);
    sval    <= (vraw > 17'd32767) ? 15'h7FFF : vraw[14:0];
    adv     <= aprod[37:14];
    prod1   <= 41'(held_sample) * 41'(signed'({1'b0, env_level}));
    if (state == S_CHK) begin
      offset <= 24'd0;
    end else if (state == S_L7) begin
      offset <= quad[1] ? (24'd0 - mag_up[30:7]) : mag[30:7];
    end
    if (state == S_IDLE) begin
      prod2 <= 58'sd0;
    end else if (state == S_O2) begin
      prod2 <= 58'(prod1) * 58'(signed'({1'b0, output_level}));
    end
  end

  // Sequencer and voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      env_phase       <= wva_pkg::ENV_IDLE;
      env_level       <= 24'd0;
      osc_phase       <= 24'd0;
      lfo_phase       <= 24'd0;
      rate_accum      <= 27'd0;
      held_sample     <= 16'sd0;
      note_phase_step <= 24'd0;
      note_lfo_step   <= 24'd0;
      bend_held       <= wva_pkg::BEND_ONE;
      wheel_held      <= 7'd0;
      nsub            <= '0;
      smp_valid       <= 1'b0;
    end else begin
      // A sample leaving in the same cycle as a new one is loaded is
      // handled by the output step below.
      if (smp_valid && !smp_stall && (state != S_O3)) begin
        smp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.opcode)
              wva_pkg::OP_TICK: begin
                state <= (env_phase == wva_pkg::ENV_IDLE) ? S_O3 : S_ENV;
              end
              wva_pkg::OP_NOTE_ON: begin
                osc_phase       <= 24'd0;
                lfo_phase       <= 24'd0;
                note_phase_step <= cmd.phase_step;
                note_lfo_step   <= cmd.lfo_step;
                env_level       <= 24'd0;
                env_phase       <= wva_pkg::ENV_ATTACK;
                rate_accum      <= wva_pkg::ACC_ONE;
                held_sample     <= 16'sd0;
              end
              wva_pkg::OP_NOTE_OFF: env_phase  <= wva_pkg::ENV_RELEASE;
              wva_pkg::OP_BEND:     bend_held  <= cmd.bend_ratio;
              wva_pkg::OP_WHEEL:    wheel_held <= cmd.wheel_value;
              default:              state      <= S_IDLE;
            endcase
          end
        end
        S_ENV: begin
          env_level  <= lvl_next[23:0];
          env_phase  <= phase_next;
          rate_accum <= acc_sum[27] ? wva_pkg::ACC_MAX : acc_sum[26:0];
          nsub       <= '0;
          state      <= S_CHK;
        end
        S_CHK: begin
          if ((nsub < MaxSubC) && (rate_accum >= wva_pkg::ACC_ONE)) begin
            rate_accum <= rate_accum - wva_pkg::ACC_ONE;
            state      <= mod_en ? S_L0 : S_RD;
          end else begin
            state <= S_O1;
          end
        end
        S_L0: state <= S_L1;
        S_L1: state <= S_L2;
        S_L2: state <= S_L3;
        S_L3: state <= S_L4;
        S_L4: state <= S_L5;
        S_L5: state <= S_L6;
        S_L6: state <= S_L7;
        S_L7: begin
          lfo_phase <= lfo_phase + note_lfo_step;
          state     <= S_RD;
        end
        S_RD: state <= S_Q;
        S_Q: begin
          held_sample <= signed'(qu);
          osc_phase   <= osc_phase + adv;
          nsub        <= nsub + NW'(1);
          state       <= S_CHK;
        end
        S_O1: state <= S_O2;
        S_O2: state <= S_O3;
        S_O3: begin
          if (out_free) begin
            smp.sample_out <= res_sat;
            smp.playing    <= (env_phase != wva_pkg::ENV_IDLE);
            smp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The idle phase is entered at reset or through a release that bottoms out at zero.
  a_idle_level_zero: assert property (@(posedge clk) disable iff (rst)
    (env_phase == wva_pkg::ENV_IDLE) |-> (env_level == 24'd0))
    else $error("envelope idle with nonzero level");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    env_level <= wva_pkg::ENV_FULL)
    else $error("envelope level above full scale");

  a_substep_limit: assert property (@(posedge clk) disable iff (rst)
    nsub <= MaxSubC)
    else $error("sub-step count beyond limit");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.opcode == wva_pkg::OP_TICK) && (env_phase == wva_pkg::ENV_IDLE))
    |=> (state == S_O3) && (prod2 == 58'sd0))
    else $error("tick on idle voice did not go straight to output");

endmodule
